// ===== sv/sldeq_pkg.sv =====
`timescale 1ns / 1ps

package sldeq_pkg;

    localparam int CAPACITY  = 16;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 4;
    localparam int ACT_W     = 2;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CNTX_W    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT    = 2'd0,
        ACT_POP_FRONT = 2'd1,
        ACT_POP_REAR  = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // write address / data selection for the entry memory
    typedef enum logic [1:0] {
        WR_UP_RDATA   = 2'd0,  // mem[idx+1] <= read data
        WR_UP_VAL     = 2'd1,  // mem[idx+1] <= new value
        WR_FRONT_VAL  = 2'd2,  // mem[0]     <= new value
        WR_DOWN_RDATA = 2'd3   // mem[idx-1] <= read data
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    idx_dec;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_result;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    empty;
        logic    full;
        logic    pos_bad;
        logic    ge;
        logic    idx_zero;
        logic    idx_last;
        logic    out_free;
    } t_stat;

endpackage

// ===== sv/sldeq_ifs.sv =====
`timescale 1ns / 1ps

interface sldeq_req_if import sldeq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface sldeq_rsp_if import sldeq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [ST_W-1:0]         status;
    logic [CNT_OUT_W-1:0]    entry_count;

    modport source (output valid, result_value, status, entry_count, input ready);
    modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

// ===== sv/sorted_list_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Sorted double-ended priority store: up to CAPACITY signed 32-bit entries, ascending.
// Request channel i_req (valid/ready): action, value, position. One transaction in,
// exactly one transaction out on o_rsp (valid/ready): result_value, status, entry_count.
// Actions: insert in order (equal values go ahead of existing equals), pop smallest,
// pop largest, read by rank. Status reports empty, invalid rank or full store.
// One request is worked at a time; i_req.ready is high only while the unit is idle.
// Rejected requests and an insert into an empty store finish at decode. Pop-largest and
// read do one read and one compare. An insert reads entries from the top down and moves
// each one up a slot until it meets a smaller one, then writes the value above it, or at
// the front if none is smaller. Pop-smallest reads every entry and moves each down a slot.
// The next request is accepted in the cycle after the response is loaded, so the unit
// never takes a new request before it is through with the last one.
// The entries sit in a single-port memory with a registered read, so each entry
// moved takes a read step and a compare/write step.
// The response sits in an output register; a new request is accepted while it
// waits. A finished request holds in the unit until that register is free.
// Reset (i_rst_n low, synchronous) empties the store and drops o_rsp.valid; entry
// contents are not cleared and need no clearing pass.

module sorted_list_double_ended_queue_unit import sldeq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sldeq_req_if.sink    i_req,
    sldeq_rsp_if.source  o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    sldeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sldeq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_req.action),
        .i_value        (i_req.value),
        .i_position     (i_req.position),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_entry_count  (o_rsp.entry_count)
    );

`ifndef NO_ASSERTIONS
    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |->
        (o_rsp.entry_count == CNT_OUT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |-> (o_rsp.entry_count == '0))
        else $error("empty status with nonzero count");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.result_value == '0))
        else $error("nonzero result on failed request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");
`endif

endmodule

// ===== sv/sldeq_ctrl.sv =====
`timescale 1ns / 1ps

module sldeq_ctrl import sldeq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_RD     = 6'b000100,
        S_CMP    = 6'b001000,
        S_PUT    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.act)
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_DONE;
                        end else if (i_stat.empty) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_FRONT_VAL;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_REAR: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ACT_READ: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INVALID;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                unique case (i_stat.act)
                    ACT_INSERT: begin
                        // walk down from the top, moving entries >= value up one slot
                        o_cmd.wr_en = 1'b1;
                        if (i_stat.ge) begin
                            o_cmd.wr_sel = WR_UP_RDATA;
                            if (i_stat.idx_zero) begin
                                n_state = S_PUT;
                            end else begin
                                o_cmd.idx_dec = 1'b1;
                                n_state       = S_RD;
                            end
                        end else begin
                            o_cmd.wr_sel  = WR_UP_VAL;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    ACT_POP_FRONT: begin
                        if (i_stat.idx_zero) begin
                            o_cmd.set_result = 1'b1;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_DOWN_RDATA;
                        end
                        if (i_stat.idx_last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    ACT_POP_REAR: begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.cnt_dec    = 1'b1;
                        n_state          = S_DONE;
                    end
                    ACT_READ: begin
                        o_cmd.set_result = 1'b1;
                        n_state          = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_FRONT_VAL;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/sldeq_dp.sv =====
`timescale 1ns / 1ps

module sldeq_dp import sldeq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    input  logic                    i_rsp_ready,
    output logic                    o_rsp_valid,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_OUT_W-1:0]    o_entry_count
);

    logic [VAL_W-1:0]        r_mem [CAPACITY];
    logic [VAL_W-1:0]        r_rdata;
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_idx;
    t_action                 r_act;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_pos;
    logic [VAL_W-1:0]        r_res_value;
    t_status                 r_res_status;
    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_value;
    t_status                 r_out_status;
    logic [CNT_W-1:0]        r_out_count;

    logic [IDX_W-1:0]  n_idx;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [IDX_W-1:0]  top_idx;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  in_pos_ext;
    logic [CNTX_W-1:0] out_cnt_ext;

    assign top_idx    = IDX_W'(r_count - CNT_W'(1));
    assign pos_ext    = CMP_W'(r_pos);
    assign cnt_ext    = CMP_W'(r_count);
    assign in_pos_ext = CMP_W'(i_position);

    // starting index of the walk for each request
    always_comb begin
        unique case (t_action'(i_action))
            ACT_INSERT:    n_idx = top_idx;
            ACT_POP_FRONT: n_idx = '0;
            ACT_POP_REAR:  n_idx = top_idx;
            ACT_READ:      n_idx = in_pos_ext[IDX_W-1:0];
            default:       n_idx = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_UP_RDATA: begin
                wr_addr = IDX_W'(r_idx + 1'b1);
                wr_data = r_rdata;
            end
            WR_UP_VAL: begin
                wr_addr = IDX_W'(r_idx + 1'b1);
                wr_data = r_val;
            end
            WR_FRONT_VAL: begin
                wr_addr = '0;
                wr_data = r_val;
            end
            WR_DOWN_RDATA: begin
                wr_addr = IDX_W'(r_idx - 1'b1);
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = '0;
                wr_data = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_val <= i_value;
            r_pos <= i_position;
        end
        if (i_cmd.load) begin
            r_idx <= n_idx;
        end else if (i_cmd.idx_dec) begin
            r_idx <= IDX_W'(r_idx - 1'b1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.load) begin
            r_res_value <= '0;
        end else if (i_cmd.set_result) begin
            r_res_value <= r_rdata;
        end
        if (i_cmd.load) begin
            r_res_status <= ST_OK;
        end else if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.act      = r_act;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CNT_W'(CAPACITY));
        o_stat.pos_bad  = (pos_ext >= cnt_ext);
        o_stat.ge       = ($signed(r_rdata) >= r_val);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (CNT_W'(r_idx) == CNT_W'(r_count - CNT_W'(1)));
        o_stat.out_free = !r_out_valid || i_rsp_ready;
    end

    assign out_cnt_ext    = CNTX_W'(r_out_count);
    assign o_rsp_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = out_cnt_ext[CNT_OUT_W-1:0];

endmodule
